// ===== sv/mtes_pkg.sv =====
// shared types and constants for the multi-timer event scheduler
package mtes_pkg;

    localparam logic [2:0] CMD_ARM    = 3'd0;
    localparam logic [2:0] CMD_ADJUST = 3'd1;
    localparam logic [2:0] CMD_ENABLE = 3'd2;
    localparam logic [2:0] CMD_SCAN   = 3'd3;
    localparam logic [2:0] CMD_ADV    = 3'd4;
    localparam logic [2:0] CMD_FEND   = 3'd5;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_OLD   = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;
    localparam logic [1:0] KIND_SLICE = 2'd3;

    localparam logic [19:0] ONE_SECOND     = 20'd1000000;
    localparam logic [19:0] FRAME_LEN_RST  = 20'd16896;
    localparam logic [20:0] OFFSET_MAX     = 21'h1FFFFF;

    typedef struct packed {
        logic [31:0] expiry;
        logic        armed;
        logic [15:0] payload;
    } timer_t;

    typedef struct packed {
        logic shift;
        logic wr;
        logic set_arm;
        logic en_wr;
        logic en_val;
        logic rebase;
    } cell_ctrl_t;

endpackage

// ===== sv/mtes_cell.sv =====
// one timer cell of the rotating timer ring
module mtes_cell
    import mtes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  logic        sel,
    input  logic [31:0] wr_expiry,
    input  logic [15:0] wr_payload,
    input  timer_t      shift_in,
    output timer_t      timer
);

    timer_t timer_reg;
    timer_t timer_next;

    always_comb
    begin
        timer_next = timer_reg;
        priority if (ctrl.shift)
        begin
            timer_next = shift_in;
        end
        else if (ctrl.wr && sel)
        begin
            timer_next.expiry  = wr_expiry;
            timer_next.payload = wr_payload;
            if (ctrl.set_arm)
            begin
                timer_next.armed = 1'b1;
            end
        end
        else if (ctrl.en_wr && sel)
        begin
            timer_next.armed = ctrl.en_val;
        end
        else if (ctrl.rebase && timer_reg.armed)
        begin
            timer_next.expiry = timer_reg.expiry - 32'(ONE_SECOND);
        end
        else
        begin
            timer_next = timer_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
        end
        else
        begin
            timer_reg <= timer_next;
        end
    end

    assign timer = timer_reg;

endmodule

// ===== sv/multi_timer_event_scheduler_core.sv =====
// top level of the multi-timer event scheduler: command decode, scan control and timer ring
//
// commands arrive on the s_ side: s_tuser carries the command code, s_tdata the
// operands. results leave on the m_ side: m_tuser carries the result kind,
// m_tdata the result fields, m_tlast marks the final result of a command.
// frame_length is written through cfg_we / cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce. arm, adjust, enable write, advance,
// frame end and unknown commands give one result each, registered, visible the cycle
// after acceptance. a scan rotates the ring of NUM_TIMERS cells one place per cycle while
// the result register is free and checks the timer at the head with one subtract and
// compare; the slice result, m_tlast set, comes after one result per fired timer in
// index order; the ring is back in place.
// one command is in progress at a time: s_tready is low during a scan and
// while an undelivered result cannot be replaced.
// when m_tready is low with a result pending, the result register holds and the scan pauses.
// reset clears all timers (disabled, zero expiry and payload), the base time,
// frame offset and second count, and sets frame_length to 16896.
module multi_timer_event_scheduler_core
    import mtes_pkg::*;
#(
    parameter int NUM_TIMERS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // timer_sel, duration, payload_in, enable_value, elapsed_us, amount
    input  logic [79:0] s_tdata,
    // cmd
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // timer_index, fired_payload, old_enable, next_ticks, seconds
    output logic [55:0] m_tdata,
    // kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SLICE = 2'd2;

    logic [2:0]  in_cmd;
    logic [2:0]  in_sel;
    logic [23:0] in_dur;
    logic [15:0] in_pay;
    logic        in_en;
    logic [15:0] in_el;
    logic [19:0] in_amt;

    assign in_sel = s_tdata[2:0];
    assign in_dur = s_tdata[26:3];
    assign in_pay = s_tdata[42:27];
    assign in_en  = s_tdata[43];
    assign in_el  = s_tdata[59:44];
    assign in_amt = s_tdata[79:60];
    assign in_cmd = s_tuser;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic [31:0]   t_reg, t_next;
    logic [19:0]   ticks_reg, ticks_next;
    logic [19:0]   base_reg, base_next;
    logic [20:0]   offset_reg, offset_next;
    logic [15:0]   sec_reg, sec_next;
    logic [19:0]   flen_reg, flen_next;

    logic          ov_reg, ov_next;
    logic [1:0]    okind_reg, okind_next;
    logic [2:0]    oidx_reg, oidx_next;
    logic [15:0]   opay_reg, opay_next;
    logic          oold_reg, oold_next;
    logic [19:0]   oticks_reg, oticks_next;
    logic [15:0]   osec_reg, osec_next;
    logic          olast_reg, olast_next;

    cell_ctrl_t        ctrl;
    timer_t            cells [NUM_TIMERS];
    timer_t            head_back;
    logic [NUM_TIMERS-1:0] armed_vec;

    logic [6:0]    sel_mod;
    logic [IW-1:0] sel_idx;
    logic [31:0]   wr_expiry;
    logic          out_free;
    logic          in_fire;
    logic [31:0]   d;
    logic          head_fire;
    logic [6:0]    cnt_wide;
    logic [19:0]   fl;
    logic [20:0]   base_sum;
    logic [21:0]   off_sum;
    logic          wrap;

    // timer select reduced modulo the ring size
    always_comb
    begin
        sel_mod = {4'b0, in_sel};
        for (int k = 0; k < 8; k++)
        begin
            if (sel_mod >= 7'(NUM_TIMERS))
            begin
                sel_mod = sel_mod - 7'(NUM_TIMERS);
            end
        end
    end

    assign sel_idx   = IW'(sel_mod);
    assign cnt_wide  = 7'(cnt_reg);
    assign wr_expiry = 32'(base_reg) + 32'(offset_reg) + 32'(in_el) + 32'(in_dur);

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;

    // head of the ring is the timer at index cnt_reg during a scan
    assign d         = cells[0].expiry - t_reg;
    assign head_fire = cells[0].armed && ((d == 32'd0) || d[31]);

    always_comb
    begin
        head_back = cells[0];
        if (head_fire)
        begin
            head_back.armed = 1'b0;
        end
    end

    assign fl       = (flen_reg > ONE_SECOND) ? ONE_SECOND : flen_reg;
    assign base_sum = 21'(base_reg) + 21'(fl);
    assign wrap     = base_sum >= 21'(ONE_SECOND);
    assign off_sum  = 22'(offset_reg) + 22'(in_amt);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        t_next      = t_reg;
        ticks_next  = ticks_reg;
        base_next   = base_reg;
        offset_next = offset_reg;
        sec_next    = sec_reg;
        flen_next   = flen_reg;
        ov_next     = ov_reg && !m_tready;
        okind_next  = okind_reg;
        oidx_next   = oidx_reg;
        opay_next   = opay_reg;
        oold_next   = oold_reg;
        oticks_next = oticks_reg;
        osec_next   = osec_reg;
        olast_next  = olast_reg;
        ctrl        = '0;
        ctrl.en_val = in_en;

        if (cfg_we)
        begin
            flen_next = cfg_wdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_ACK;
                    oidx_next   = 3'd0;
                    opay_next   = 16'd0;
                    oold_next   = 1'b0;
                    oticks_next = 20'd0;
                    osec_next   = 16'd0;
                    olast_next  = 1'b1;
                    unique case (in_cmd)
                        CMD_ARM, CMD_ADJUST:
                        begin
                            ctrl.wr      = 1'b1;
                            ctrl.set_arm = (in_cmd == CMD_ARM);
                            oidx_next    = sel_mod[2:0];
                        end
                        CMD_ENABLE:
                        begin
                            ctrl.en_wr = 1'b1;
                            okind_next = KIND_OLD;
                            oidx_next  = sel_mod[2:0];
                            oold_next  = armed_vec[sel_idx];
                        end
                        CMD_SCAN:
                        begin
                            ov_next    = 1'b0;
                            t_next     = 32'(base_reg) + 32'(offset_reg);
                            ticks_next = in_amt;
                            cnt_next   = '0;
                            state_next = ST_SCAN;
                        end
                        CMD_ADV:
                        begin
                            offset_next = (off_sum > 22'(OFFSET_MAX)) ? OFFSET_MAX
                                                                       : off_sum[20:0];
                        end
                        CMD_FEND:
                        begin
                            offset_next = 21'd0;
                            if (wrap)
                            begin
                                base_next   = 20'(base_sum - 21'(ONE_SECOND));
                                sec_next    = sec_reg + 16'd1;
                                ctrl.rebase = 1'b1;
                                osec_next   = sec_reg + 16'd1;
                            end
                            else
                            begin
                                base_next = base_sum[19:0];
                                osec_next = sec_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    ctrl.shift = 1'b1;
                    if (head_fire)
                    begin
                        ov_next     = 1'b1;
                        okind_next  = KIND_FIRED;
                        oidx_next   = cnt_wide[2:0];
                        opay_next   = cells[0].payload;
                        oold_next   = 1'b0;
                        oticks_next = 20'd0;
                        osec_next   = 16'd0;
                        olast_next  = 1'b0;
                    end
                    else if (cells[0].armed && !d[31] && (d < 32'(ticks_reg)))
                    begin
                        ticks_next = d[19:0];
                    end
                    if (cnt_reg == IW'(NUM_TIMERS - 1))
                    begin
                        state_next = ST_SLICE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IW'(1);
                    end
                end
            end
            ST_SLICE:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_SLICE;
                    oidx_next   = 3'd0;
                    opay_next   = 16'd0;
                    oold_next   = 1'b0;
                    oticks_next = ticks_reg;
                    osec_next   = 16'd0;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            base_reg   <= 20'd0;
            offset_reg <= 21'd0;
            sec_reg    <= 16'd0;
            flen_reg   <= FRAME_LEN_RST;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            base_reg   <= base_next;
            offset_reg <= offset_next;
            sec_reg    <= sec_next;
            flen_reg   <= flen_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        ticks_reg  <= ticks_next;
        okind_reg  <= okind_next;
        oidx_reg   <= oidx_next;
        opay_reg   <= opay_next;
        oold_reg   <= oold_next;
        oticks_reg <= oticks_next;
        osec_reg   <= osec_next;
        olast_reg  <= olast_next;
    end

    // ring of timer cells, each shifting toward index zero
    for (genvar k = 0; k < NUM_TIMERS; k++)
    begin : g_cell
        timer_t shift_src;
        if (k == NUM_TIMERS - 1)
        begin : g_tail
            assign shift_src = head_back;
        end
        else
        begin : g_mid
            assign shift_src = cells[k + 1];
        end

        mtes_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sel        (sel_idx == IW'(k)),
            .wr_expiry  (wr_expiry),
            .wr_payload (in_pay),
            .shift_in   (shift_src),
            .timer      (cells[k])
        );

        assign armed_vec[k] = cells[k].armed;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {osec_reg, oticks_reg, oold_reg, opay_reg, oidx_reg};

endmodule

// ===== dv/multi_timer_event_scheduler_core_tb.sv =====
// testbench for multi_timer_event_scheduler_core: directed and random command streams checked against a predictor
`timescale 1ns / 1ps

module multi_timer_event_scheduler_core_tb
    import mtes_pkg::*;
;

    localparam int NUM_TIMERS = 8;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 24;
    localparam int PRINT_CAP = 100;

    // s_tdata layout, lowest bit first: sel, dur, pay, en, elapsed, amount
    typedef struct packed {
        logic [19:0] amount;
        logic [15:0] elapsed;
        logic        en;
        logic [15:0] pay;
        logic [23:0] dur;
        logic [2:0]  sel;
    } cmd_fields_t;

    // m_tdata layout, lowest bit first: idx, pay, old, ticks, seconds
    typedef struct packed {
        logic [15:0] seconds;
        logic [19:0] ticks;
        logic        old;
        logic [15:0] pay;
        logic [2:0]  idx;
    } result_data_t;

    typedef struct packed {
        logic [1:0]   kind;
        result_data_t data;
        logic         last;
    } timer_result_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    class timer_scoreboard;
        logic [31:0]   expiry [NUM_TIMERS];
        logic          armed [NUM_TIMERS];
        logic [15:0]   payload [NUM_TIMERS];
        logic [31:0]   base;
        logic [31:0]   frame_ofs;
        logic [15:0]   second_cnt;
        logic [19:0]   frame_len;
        timer_result_t expected_q [$];
        int            errors;

        function new();
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                expiry[i] = '0;
                armed[i] = 1'b0;
                payload[i] = '0;
            end
            base = '0;
            frame_ofs = '0;
            second_cnt = '0;
            frame_len = FRAME_LEN_RST;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(logic [1:0] kind, logic [2:0] idx, logic [15:0] pay,
                                  logic old, logic [19:0] ticks, logic [15:0] secs,
                                  logic last);
            timer_result_t r;
            r.kind = kind;
            r.data.idx = idx;
            r.data.pay = pay;
            r.data.old = old;
            r.data.ticks = ticks;
            r.data.seconds = secs;
            r.last = last;
            expected_q.push_back(r);
        endfunction

        function void note_command(logic [2:0] c, cmd_fields_t f);
            logic [31:0] now;
            logic [31:0] t;
            logic [31:0] ticks;
            logic [31:0] d;
            logic [31:0] s;
            logic [31:0] fl;
            logic        neg;
            now = base + frame_ofs + 32'(f.elapsed);
            case (c)
                CMD_ARM, CMD_ADJUST:
                begin
                    if (c == CMD_ARM)
                        armed[f.sel] = 1'b1;
                    expiry[f.sel] = now + 32'(f.dur);
                    payload[f.sel] = f.pay;
                    push_result(KIND_ACK, f.sel, '0, 1'b0, '0, '0, 1'b1);
                end
                CMD_ENABLE:
                begin
                    push_result(KIND_OLD, f.sel, '0, armed[f.sel], '0, '0, 1'b1);
                    armed[f.sel] = f.en;
                end
                CMD_SCAN:
                begin
                    t = base + frame_ofs;
                    ticks = 32'(f.amount);
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        d = expiry[i] - t;
                        neg = d[31];
                        if (armed[i] && (d == 0 || neg))
                        begin
                            armed[i] = 1'b0;
                            push_result(KIND_FIRED, 3'(i), payload[i], 1'b0, '0, '0, 1'b0);
                        end
                        if (armed[i] && !neg && d < ticks)
                            ticks = d;
                    end
                    push_result(KIND_SLICE, '0, '0, 1'b0, ticks[19:0], '0, 1'b1);
                end
                CMD_ADV:
                begin
                    s = frame_ofs + 32'(f.amount);
                    frame_ofs = (s > 32'(OFFSET_MAX)) ? 32'(OFFSET_MAX) : s;
                    push_result(KIND_ACK, '0, '0, 1'b0, '0, '0, 1'b1);
                end
                CMD_FEND:
                begin
                    fl = (frame_len > ONE_SECOND) ? 32'(ONE_SECOND) : 32'(frame_len);
                    base = base + fl;
                    if (base >= 32'(ONE_SECOND))
                    begin
                        base = base - 32'(ONE_SECOND);
                        second_cnt = second_cnt + 16'd1;
                        for (int i = 0; i < NUM_TIMERS; i++)
                            if (armed[i])
                                expiry[i] = expiry[i] - 32'(ONE_SECOND);
                    end
                    frame_ofs = '0;
                    push_result(KIND_ACK, '0, '0, 1'b0, '0, second_cnt, 1'b1);
                end
                default:
                    push_result(KIND_ACK, '0, '0, 1'b0, '0, '0, 1'b1);
            endcase
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] exp);
            if (got !== exp)
                report($sformatf("%s got %0h expected %0h", name, got, exp));
        endtask

        task check_result(logic [1:0] kind, logic [55:0] data, logic last);
            timer_result_t e;
            result_data_t  got;
            got = data;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing pending, kind %0h data %0h", kind, data));
                return;
            end
            e = expected_q.pop_front();
            check_field("kind", 32'(kind), 32'(e.kind));
            check_field("timer_index", 32'(got.idx), 32'(e.data.idx));
            check_field("fired_payload", 32'(got.pay), 32'(e.data.pay));
            check_field("old_enable", 32'(got.old), 32'(e.data.old));
            check_field("next_ticks", 32'(got.ticks), 32'(e.data.ticks));
            check_field("seconds", 32'(got.seconds), 32'(e.data.seconds));
            check_field("last", 32'(last), 32'(e.last));
        endtask

        task check_leftover();
            while (expected_q.size() != 0)
            begin
                report($sformatf("result never delivered, kind %0h", expected_q[0].kind));
                void'(expected_q.pop_front());
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [19:0] cfg_wdata;

    timer_scoreboard sb;
    bit              hold_req = 1'b0;
    bit              full_rate = 1'b0;
    int              quiet_cycles = 0;

    multi_timer_event_scheduler_core #(
        .NUM_TIMERS(NUM_TIMERS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("multi_timer_event_scheduler_core verification failed");
            $finish;
        end
    end

    // receiver stall pattern
    initial
    begin
        rx_mode_e mode;
        int       mode_left;
        int       rx_cycle;
        logic     rdy;
        mode = RX_ALWAYS;
        mode_left = 0;
        rx_cycle = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                rx_cycle++;
                case (mode)
                    RX_ALWAYS:   rdy = 1'b1;
                    RX_COIN:     rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
                    default:     rdy = (rx_cycle % 3 != 0);
                endcase
                m_tready <= full_rate ? 1'b1 : rdy;
            end
        end
    end

    function automatic cmd_fields_t pack_cmd(logic [2:0] sel, logic [23:0] dur,
                                             logic [15:0] pay, logic en,
                                             logic [15:0] elapsed, logic [19:0] amount);
        cmd_fields_t f;
        f.sel = sel;
        f.dur = dur;
        f.pay = pay;
        f.en = en;
        f.elapsed = elapsed;
        f.amount = amount;
        return f;
    endfunction

    function automatic cmd_fields_t rand_fields(logic [2:0] c);
        cmd_fields_t f;
        int          r;
        f.sel = 3'($urandom_range(0, 7));
        f.pay = 16'($urandom);
        f.en = 1'($urandom_range(0, 1));
        f.elapsed = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)
            f.dur = 24'($urandom_range(0, 20000));
        else if (r < 90)
            f.dur = 24'($urandom_range(0, 200000));
        else
            f.dur = 24'($urandom);
        r = $urandom_range(0, 99);
        if (c == CMD_SCAN && r < 10)
            f.amount = '0;
        else if (c == CMD_ADV && r < 70)
            f.amount = 20'($urandom_range(0, 20000));
        else
            f.amount = 20'($urandom);
        return f;
    endfunction

    task automatic send_cmd(logic [2:0] c, cmd_fields_t f);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= f;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(c, f);
    endtask

    task automatic idle_gap(int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata <= 80'({$urandom, $urandom, $urandom});
        s_tuser <= 3'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain();
        idle_gap(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_length(logic [19:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 20'($urandom);
        sb.frame_len = v;
    endtask

    task automatic send_random_cmds(int count);
        int         burst_left;
        int         r;
        logic [2:0] c;
        burst_left = $urandom_range(1, 12);
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
                c = CMD_ARM;
            else if (r < 30)
                c = CMD_ADJUST;
            else if (r < 40)
                c = CMD_ENABLE;
            else if (r < 60)
                c = CMD_SCAN;
            else if (r < 80)
                c = CMD_ADV;
            else if (r < 92)
                c = CMD_FEND;
            else
                c = ($urandom_range(0, 1) == 0) ? CMD_RSVD6 : CMD_RSVD7;
            send_cmd(c, rand_fields(c));
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 29) == 0)
                    drain();
                else
                    idle_gap($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    initial
    begin
        logic [19:0] settings [5];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // never-written timer enabled with zero expiry, fires at once with zero slice limit
        send_cmd(CMD_ENABLE, pack_cmd(3'd5, '0, '0, 1'b1, '0, '0));
        send_cmd(CMD_SCAN, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'd0));
        send_cmd(CMD_ARM, pack_cmd(3'd0, 24'd0, 16'hFFFF, 1'b0, 16'hFFFF, '0));
        send_cmd(CMD_ARM, pack_cmd(3'd7, 24'hFFFFFF, 16'h1234, 1'b1, 16'd0, 20'hFFFFF));
        // adjust on a disabled timer leaves it disabled
        send_cmd(CMD_ADJUST, pack_cmd(3'd3, 24'd50, 16'hA5A5, 1'b0, 16'd0, '0));
        send_cmd(CMD_ENABLE, pack_cmd(3'd3, '0, '0, 1'b1, '0, '0));
        send_cmd(CMD_SCAN, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'hFFFFF));
        send_cmd(CMD_ADV, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'd50));
        send_cmd(CMD_SCAN, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'hFFFFF));
        // offset saturation
        send_cmd(CMD_ADV, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'hFFFFF));
        send_cmd(CMD_ADV, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'hFFFFF));
        send_cmd(CMD_SCAN, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'd0));
        send_cmd(CMD_ENABLE, pack_cmd(3'd0, '0, '0, 1'b0, '0, '0));
        send_cmd(CMD_ENABLE, pack_cmd(3'd7, '0, '0, 1'b0, '0, '0));
        send_cmd(CMD_FEND, pack_cmd(3'd0, '0, '0, 1'b0, '0, '0));
        send_cmd(CMD_RSVD6, pack_cmd(3'd7, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 20'hFFFFF));
        send_cmd(CMD_RSVD7, pack_cmd(3'd2, 24'd1, 16'd1, 1'b0, 16'd1, 20'd1));
        // every timer due in the same scan
        for (int i = 0; i < NUM_TIMERS; i++)
            send_cmd(CMD_ARM, pack_cmd(3'(i), '0, 16'($urandom), 1'b0, '0, '0));
        send_cmd(CMD_SCAN, pack_cmd(3'd0, '0, '0, 1'b0, '0, 20'd1000));

        settings[0] = FRAME_LEN_RST;
        settings[1] = 20'd1;
        settings[2] = ONE_SECOND;
        settings[3] = 20'hFFFFF;
        settings[4] = 20'($urandom_range(1, 20'hFFFFF));
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_frame_length(settings[p]);
            end
            if (p == 0)
                hold_req = 1'b1;
            send_random_cmds(RANDOM_PER_PHASE);
        end

        // second counter steps on every frame end, back to back with receiver always ready
        drain();
        write_frame_length(ONE_SECOND);
        full_rate = 1'b1;
        repeat (8) send_cmd(CMD_FEND, rand_fields(CMD_FEND));
        drain();
        full_rate = 1'b0;

        repeat (20) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("multi_timer_event_scheduler_core verification clean");
        else
            $display("multi_timer_event_scheduler_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mtes_pkg.sv
sv/mtes_cell.sv
sv/multi_timer_event_scheduler_core.sv
dv/multi_timer_event_scheduler_core_tb.sv
